FILE: rtl/rbp_pkg.sv
// Package for the relative bearing block: widths, the CORDIC arctangent table
// and the data word that travels down the cell chain. No dependencies.
`default_nettype none

package rbp_pkg;

    localparam int RBP_COORD_W      = 32;
    localparam int RBP_DIFF_W       = RBP_COORD_W + 1;
    localparam int RBP_FRAC_W       = 24;                         // prescale by 2^24
    localparam int RBP_XY_W         = RBP_DIFF_W + RBP_FRAC_W + 3; // headroom for gain
    localparam int RBP_ANGLE_W      = 32;
    localparam int RBP_BAM_W        = 16;
    localparam int RBP_TABLE_LEN    = 24;
    localparam int RBP_IDX_W        = 5;
    localparam int RBP_CORDIC_STEPS = 16;

    localparam logic [RBP_ANGLE_W-1:0] RBP_ANG_PLUS_90  = 32'h4000_0000;
    localparam logic [RBP_ANGLE_W-1:0] RBP_ANG_MINUS_90 = 32'hC000_0000;

    typedef struct packed {
        logic signed [RBP_XY_W-1:0]  x;
        logic signed [RBP_XY_W-1:0]  y;
        logic [RBP_ANGLE_W-1:0]      z;
        logic                        zero;
        logic [RBP_BAM_W-1:0]        heading;
    } t_cordic_data;

    // atan(2^-i) scaled so that 2^32 is one full turn
    function automatic logic [RBP_ANGLE_W-1:0] atan_entry(input logic [RBP_IDX_W-1:0] idx);
        logic [RBP_ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2FA;
            5'd15:   v = 32'h0000_517D;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A30;
            5'd19:   v = 32'h0000_0518;
            5'd20:   v = 32'h0000_028C;
            5'd21:   v = 32'h0000_0146;
            5'd22:   v = 32'h0000_00A3;
            5'd23:   v = 32'h0000_0051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rbp_front.sv
// Front end of the bearing pipeline: forms dx/dy, then prescales and folds the
// left half-plane into the right one. Depends on rbp_pkg.
`default_nettype none

module rbp_front
    import rbp_pkg::*;
(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic signed [RBP_COORD_W-1:0] i_target_x,
    input  wire logic signed [RBP_COORD_W-1:0] i_target_y,
    input  wire logic signed [RBP_COORD_W-1:0] i_robot_x,
    input  wire logic signed [RBP_COORD_W-1:0] i_robot_y,
    input  wire logic        [RBP_BAM_W-1:0]   i_robot_heading,
    output logic                               o_valid,
    output t_cordic_data                       o_data
);

    logic                         r_valid_a;
    logic signed [RBP_DIFF_W-1:0] r_dx;
    logic signed [RBP_DIFF_W-1:0] r_dy;
    logic [RBP_BAM_W-1:0]         r_head;
    logic                         r_valid_b;
    t_cordic_data                 r_data;
    t_cordic_data                 n_data;
    logic signed [RBP_XY_W-1:0]   sx;
    logic signed [RBP_XY_W-1:0]   sy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dx   <= RBP_DIFF_W'(i_target_x) - RBP_DIFF_W'(i_robot_x);
        r_dy   <= RBP_DIFF_W'(i_target_y) - RBP_DIFF_W'(i_robot_y);
        r_head <= i_robot_heading;
        r_data <= n_data;
    end

    always_comb begin
        sx = RBP_XY_W'({r_dx, {RBP_FRAC_W{1'b0}}});
        sy = RBP_XY_W'({r_dy, {RBP_FRAC_W{1'b0}}});
        // sign-extend: the sized cast zero-fills the top three bits
        sx[RBP_XY_W-1 -: 3] = {3{r_dx[RBP_DIFF_W-1]}};
        sy[RBP_XY_W-1 -: 3] = {3{r_dy[RBP_DIFF_W-1]}};
        n_data.zero    = (r_dx == '0) && (r_dy == '0);
        n_data.heading = r_head;
        n_data.x       = sx;
        n_data.y       = sy;
        n_data.z       = '0;
        if (sx < 0) begin
            if (sy >= 0) begin
                n_data.x = sy;
                n_data.y = -sx;
                n_data.z = RBP_ANG_PLUS_90;
            end else begin
                n_data.x = -sy;
                n_data.y = sx;
                n_data.z = RBP_ANG_MINUS_90;
            end
        end
    end

    assign o_valid = r_valid_b;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: rtl/rbp_cell.sv
// One vectoring CORDIC micro-rotation, registered; STEP fixes shift and angle.
// Depends on rbp_pkg.
`default_nettype none

module rbp_cell
    import rbp_pkg::*;
#(
    parameter int STEP = 0
)(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire t_cordic_data i_data,
    output logic              o_valid,
    output t_cordic_data      o_data
);

    localparam logic [RBP_ANGLE_W-1:0] ANG = atan_entry(RBP_IDX_W'(STEP));

    logic                       r_valid;
    t_cordic_data               r_data;
    t_cordic_data               n_data;
    logic signed [RBP_XY_W-1:0] xs;
    logic signed [RBP_XY_W-1:0] ys;

    always_comb begin
        xs     = i_data.x >>> STEP;
        ys     = i_data.y >>> STEP;
        n_data = i_data;
        if (!i_data.y[RBP_XY_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + ANG;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - ANG;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

`default_nettype wire

FILE: rtl/relative_bearing_to_point_top.sv
// One rbp_cell per step (CORDIC_STEPS, capped at 24) between rbp_front and the output register.
// Throughput: one item per cycle; every stage of the cell chain is registered, so
// busy is never raised and the receiver takes each done strobe as it comes.
// Reset: synchronous, active low; clears the valid chain, payload registers keep state.
// Depends on rbp_pkg, rbp_front, rbp_cell.
`default_nettype none

module relative_bearing_to_point_top
    import rbp_pkg::*;
#(
    parameter int CORDIC_STEPS = RBP_CORDIC_STEPS
)(
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [RBP_COORD_W-1:0] i_target_x,
    input  wire logic signed [RBP_COORD_W-1:0] i_target_y,
    input  wire logic signed [RBP_COORD_W-1:0] i_robot_x,
    input  wire logic signed [RBP_COORD_W-1:0] i_robot_y,
    input  wire logic signed [RBP_BAM_W-1:0]   i_robot_heading,
    output logic                               o_done,
    output logic signed [RBP_BAM_W-1:0]        o_relative_bearing
);

    localparam int NSTEPS = (CORDIC_STEPS > RBP_TABLE_LEN) ? RBP_TABLE_LEN : CORDIC_STEPS;

    logic         chain_valid [NSTEPS+1];
    t_cordic_data chain_data  [NSTEPS+1];

    logic                 r_done;
    logic [RBP_BAM_W-1:0] r_bear;
    logic [RBP_BAM_W-1:0] abs16;
    t_cordic_data         last;

    assign busy = 1'b0;

    rbp_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (start),
        .i_target_x      (i_target_x),
        .i_target_y      (i_target_y),
        .i_robot_x       (i_robot_x),
        .i_robot_y       (i_robot_y),
        .i_robot_heading (i_robot_heading),
        .o_valid         (chain_valid[0]),
        .o_data          (chain_data[0])
    );

    for (genvar g = 0; g < NSTEPS; g++) begin : g_cell
        rbp_cell #(.STEP(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (chain_valid[g]),
            .i_data  (chain_data[g]),
            .o_valid (chain_valid[g+1]),
            .o_data  (chain_data[g+1])
        );
    end

    // round the 32-bit angle to 16 bits (zero for a zero vector), then subtract heading mod 2^16
    always_comb begin
        last  = chain_data[NSTEPS];
        abs16 = last.z[RBP_ANGLE_W-1 -: RBP_BAM_W] + RBP_BAM_W'(last.z[RBP_ANGLE_W-RBP_BAM_W-1]);
        if (last.zero) begin
            abs16 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= chain_valid[NSTEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bear <= abs16 - last.heading;
    end

    assign o_done             = r_done;
    assign o_relative_bearing = r_bear;

endmodule

`default_nettype wire

FILE: rtl/rbp_checker.sv
// Port-level checks for relative_bearing_to_point_top, attached by bind.
// Depends on rbp_pkg.
`default_nettype none

module rbp_checker
    import rbp_pkg::*;
#(
    parameter int CORDIC_STEPS = RBP_CORDIC_STEPS
)(
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic signed [RBP_COORD_W-1:0] i_target_x,
    input wire logic signed [RBP_COORD_W-1:0] i_target_y,
    input wire logic signed [RBP_COORD_W-1:0] i_robot_x,
    input wire logic signed [RBP_COORD_W-1:0] i_robot_y,
    input wire logic signed [RBP_BAM_W-1:0]   i_robot_heading,
    input wire logic                          o_done,
    input wire logic signed [RBP_BAM_W-1:0]   o_relative_bearing
);

    localparam int NSTEPS = (CORDIC_STEPS > RBP_TABLE_LEN) ? RBP_TABLE_LEN : CORDIC_STEPS;
    localparam int LAT    = NSTEPS + 3;

    // pipeline never stalls the sender
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !busy)
        else $error("busy raised");

    // every done traces back to an earlier start at the input
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("done without matching start");

    // target on the robot: absolute angle is zero, so the result is minus heading
    a_zero_vector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_target_x == i_robot_x && i_target_y == i_robot_y, LAT))
        |-> (o_relative_bearing == RBP_BAM_W'(-$past(i_robot_heading, LAT))))
        else $error("zero vector bearing wrong");

endmodule

bind relative_bearing_to_point_top rbp_checker #(.CORDIC_STEPS(CORDIC_STEPS)) u_rbp_checker (.*);

`default_nettype wire
